[rtl/dvbp_pkg.sv]
package dvbp_pkg;

  localparam int MaxBlockBytes = 512;
  localparam int MinBlockBytes = 8;
  localparam int WordBytes     = 8;
  localparam int AddrW         = $clog2(MaxBlockBytes);
  localparam int WordIdxW      = $clog2(MaxBlockBytes / WordBytes);
  localparam int Depth         = MaxBlockBytes / WordBytes;
  localparam int OutW          = 168;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic decide;
    logic load_k;
    logic load_v;
    logic put_step;
    logic items_inc;
    logic emit_start;
    logic load_word;
    logic word_next;
    logic emit_done;
    logic load_report;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic do_pre;
    logic do_put;
    logic do_post;
    logic has_items;
    logic put_last;
    logic last_word;
  } stat_t;

  // Encoded length of a varint in bytes
  function automatic logic [2:0] vsize(input logic [31:0] x);
    logic [2:0] n;
    begin
      if (x[31:7] == '0) n = 3'd1;
      else if (x[31:14] == '0) n = 3'd2;
      else if (x[31:21] == '0) n = 3'd3;
      else if (x[31:28] == '0) n = 3'd4;
      else n = 3'd5;
      return n;
    end
  endfunction

endpackage

[rtl/dvbp_datapath.sv]
module dvbp_datapath
  import dvbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic [9:0]      cfg_wdata,
  input  logic            in_op,
  input  logic [31:0]     in_key,
  input  logic [31:0]     in_value,
  input  cmd_t            cmd,
  output stat_t           stat,
  output logic [OutW-1:0] out_data,
  output logic            out_last
);

  logic [9:0]  block_size;
  logic [9:0]  fill_bytes;
  logic [15:0] items_in_block;
  logic [31:0] previous_key;
  logic [31:0] previous_value;
  logic [31:0] running_checksum;
  logic [31:0] block_counter;

  logic        op;
  logic [31:0] key;
  logic [31:0] value;
  logic [31:0] kd_reg;
  logic [31:0] vd_reg;
  logic [31:0] shifter;
  logic        fresh;
  logic        err;
  logic [WordIdxW-1:0] wcnt;

  logic [63:0] mem [Depth];
  logic [63:0] rdata;

  logic [63:0] o_word;
  logic [3:0]  o_bytes;
  logic        o_end;
  logic [31:0] o_ikey;
  logic        o_ivalid;
  logic        o_err;

  // Effective block size and word count
  logic [9:0]  bs;
  logic [6:0]  nwords;
  always_comb begin
    if (block_size < 10'(MinBlockBytes)) bs = 10'(MinBlockBytes);
    else if (block_size > 10'(MaxBlockBytes)) bs = 10'(MaxBlockBytes);
    else bs = block_size;
    nwords = 7'((11'(bs) + 11'd7) >> 3);
  end

  // Item classification on latched input
  logic [31:0] kd;
  logic [31:0] vd;
  logic [10:0] need;
  logic        bad;
  logic        add_ok;
  always_comb begin
    kd = (items_in_block != '0) ? key - previous_key : '0;
    vd = (items_in_block != '0 && kd == '0) ? value - previous_value : value;
    need = 11'(fill_bytes) + 11'd2 + 11'(vsize(vd))
         + ((items_in_block != '0) ? 11'(vsize(kd)) : 11'd0);
    bad = (key < previous_key) || (key == previous_key && value < previous_value);
    add_ok = (op == OP_ADD) && !bad;
  end

  assign stat.do_pre    = (add_ok && need > 11'(bs))
                        || (op == OP_FINISH && items_in_block != '0);
  assign stat.do_put    = add_ok;
  assign stat.do_post   = add_ok && need == 11'(bs);
  assign stat.has_items = items_in_block != '0;
  assign stat.put_last  = shifter[31:7] == '0;
  assign stat.last_word = 7'(wcnt) == nwords - 7'd1;

  // Byte write position, body starts after the two-byte header
  logic [AddrW-1:0] wpos;
  assign wpos = AddrW'(fill_bytes) + AddrW'(2);

  // Block memory: byte writes, registered word reads
  always_ff @(posedge clk) begin
    if (cmd.put_step) begin
      mem[wpos[AddrW-1:3]][{wpos[2:0], 3'b000} +: 8] <=
        {(shifter[31:7] != '0), shifter[6:0]};
    end
    rdata <= mem[wcnt];
  end

  // Assemble one block word
  logic [63:0] word;
  logic [9:0]  rem;
  logic [3:0]  nb;
  always_comb begin
    logic [AddrW-1:0] p;
    rem = bs - {wcnt, 3'b000};
    nb = (rem > 10'd8) ? 4'd8 : rem[3:0];
    for (int i = 0; i < WordBytes; i++) begin
      p = {wcnt, 3'(i)};
      if (p == '0) word[i*8 +: 8] = items_in_block[15:8];
      else if (p == AddrW'(1)) word[i*8 +: 8] = items_in_block[7:0];
      else if (10'(p) < fill_bytes + 10'd2 && 4'(i) < nb) word[i*8 +: 8] = rdata[i*8 +: 8];
      else word[i*8 +: 8] = 8'd0;
    end
  end

  // Control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size       <= 10'(MaxBlockBytes);
      fill_bytes       <= '0;
      items_in_block   <= '0;
      previous_key     <= '0;
      previous_value   <= '0;
      running_checksum <= '0;
      block_counter    <= '0;
    end else if (cfg_wen) begin
      block_size     <= cfg_wdata;
      fill_bytes     <= '0;
      items_in_block <= '0;
    end else begin
      if (cmd.decide && add_ok) begin
        running_checksum <= running_checksum ^ key ^ value;
        previous_key     <= key;
        previous_value   <= value;
      end
      if (cmd.decide && (stat.do_pre || stat.do_post)) block_counter <= block_counter + 32'd1;
      if (cmd.put_step) fill_bytes <= fill_bytes + 10'd1;
      if (cmd.items_inc) items_in_block <= items_in_block + 16'd1;
      if (cmd.emit_done) begin
        fill_bytes     <= '0;
        items_in_block <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op    <= in_op;
      key   <= in_key;
      value <= in_value;
    end
    if (cmd.decide) begin
      kd_reg  <= kd;
      vd_reg  <= stat.do_pre ? value : vd;
      fresh   <= add_ok && (items_in_block == '0 || need > 11'(bs));
      err     <= (op == OP_ADD) && bad;
    end
    if (cmd.load_k) shifter <= kd_reg;
    else if (cmd.load_v) shifter <= vd_reg;
    else if (cmd.put_step) shifter <= shifter >> 7;
    if (cmd.emit_start) wcnt <= '0;
    else if (cmd.word_next) wcnt <= wcnt + WordIdxW'(1);
    if (cmd.load_word) begin
      o_word   <= word;
      o_bytes  <= nb;
      o_end    <= stat.last_word;
      o_ikey   <= (stat.last_word && fresh) ? key : '0;
      o_ivalid <= stat.last_word && fresh;
      o_err    <= 1'b0;
      out_last <= stat.last_word;
    end else if (cmd.load_report) begin
      o_word   <= '0;
      o_bytes  <= '0;
      o_end    <= 1'b0;
      o_ikey   <= fresh ? key : '0;
      o_ivalid <= fresh;
      o_err    <= err;
      out_last <= 1'b1;
    end
  end

  assign out_data = {1'b0, o_err, block_counter, running_checksum, o_ivalid, o_ikey,
                     o_end, o_bytes, o_word};

endmodule

[rtl/dvbp_ctrl.sv]
module dvbp_ctrl
  import dvbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_PUT_START = 4'd2;
  localparam logic [3:0] S_PUTK      = 4'd3;
  localparam logic [3:0] S_PUTV      = 4'd4;
  localparam logic [3:0] S_EMIT_RD   = 4'd5;
  localparam logic [3:0] S_EMIT_LD   = 4'd6;
  localparam logic [3:0] S_EMIT_WAIT = 4'd7;
  localparam logic [3:0] S_REP_LD    = 4'd8;
  localparam logic [3:0] S_REP_WAIT  = 4'd9;

  logic [3:0] state, state_next;
  logic       post_phase, post_phase_next;
  logic       do_pre, do_pre_next;
  logic       do_put, do_put_next;
  logic       do_post, do_post_next;

  assign s_tready = state == S_IDLE;
  assign m_tvalid = state == S_EMIT_WAIT || state == S_REP_WAIT;

  // Next state and commands
  always_comb begin
    state_next      = state;
    post_phase_next = post_phase;
    do_pre_next     = do_pre;
    do_put_next     = do_put;
    do_post_next    = do_post;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide      = 1'b1;
        do_pre_next     = stat.do_pre;
        do_put_next     = stat.do_put;
        do_post_next    = stat.do_post;
        post_phase_next = 1'b0;
        if (stat.do_pre) begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT_RD;
        end else if (stat.do_put) state_next = S_PUT_START;
        else state_next = S_REP_LD;
      end
      S_PUT_START: begin
        if (stat.has_items) begin
          cmd.load_k = 1'b1;
          state_next = S_PUTK;
        end else begin
          cmd.load_v = 1'b1;
          state_next = S_PUTV;
        end
      end
      S_PUTK: begin
        cmd.put_step = 1'b1;
        if (stat.put_last) begin
          cmd.load_v = 1'b1;
          state_next = S_PUTV;
        end
      end
      S_PUTV: begin
        cmd.put_step = 1'b1;
        if (stat.put_last) begin
          cmd.items_inc = 1'b1;
          if (do_post) begin
            cmd.emit_start  = 1'b1;
            post_phase_next = 1'b1;
            state_next      = S_EMIT_RD;
          end else if (do_pre) state_next = S_IDLE;
          else state_next = S_REP_LD;
        end
      end
      S_EMIT_RD: state_next = S_EMIT_LD;
      S_EMIT_LD: begin
        cmd.load_word = 1'b1;
        state_next    = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (m_tready) begin
          if (stat.last_word) begin
            cmd.emit_done = 1'b1;
            if (!post_phase && do_put) state_next = S_PUT_START;
            else state_next = S_IDLE;
          end else begin
            cmd.word_next = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      S_REP_LD: begin
        cmd.load_report = 1'b1;
        state_next      = S_REP_WAIT;
      end
      S_REP_WAIT: if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      post_phase <= 1'b0;
      do_pre     <= 1'b0;
      do_put     <= 1'b0;
      do_post    <= 1'b0;
    end else begin
      state      <= state_next;
      post_phase <= post_phase_next;
      do_pre     <= do_pre_next;
      do_put     <= do_put_next;
      do_post    <= do_post_next;
    end
  end

  // Never take an item while a beat is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input taken with beat pending");

  // A stalled beat keeps its state
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("beat dropped");

  // Words follow a load cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_EMIT_WAIT) |-> $past(state) == S_EMIT_LD)
    else $error("word shown without load");

endmodule

[rtl/delta_varint_block_packer_top.sv]
// Delta varint block packer. An item is written one varint byte per cycle
// (up to 10 bytes) into the block memory; a dropped item or a finish with
// nothing to flush writes nothing. An emitted block goes out one 64-bit word
// (up to 64 words) at a time through the read, load and wait states and the
// single registered memory read port, each word held while the output stalls.
// Finish flushes a partial block. Write block_size only while idle; a write
// drops any partial block.
module delta_varint_block_packer_top
  import dvbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic [9:0]      cfg_wdata,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [63:0]     s_tdata,   // key[31:0], value[63:32]
  input  logic            s_tuser,   // operation
  output logic            m_tvalid,
  input  logic            m_tready,
  // block_word[63:0], word_bytes[67:64], block_end[68], index_key[100:69],
  // index_valid[101], checksum[133:102], blocks_written[165:134],
  // order_error[166], zero[167]
  output logic [OutW-1:0] m_tdata,
  output logic            m_tlast    // last
);

  cmd_t  cmd;
  stat_t stat;

  dvbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dvbp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_op     (s_tuser),
    .in_key    (s_tdata[31:0]),
    .in_value  (s_tdata[63:32]),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
